@@ src/binary_heap_priority_queue_core_assert.svh @@
// Assertion macros for the binary heap priority queue core.
// Each expects signals clk and rst in the scope where it is used.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Checked only outside reset.
`define BHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define BHPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/bhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types and codes for the binary heap priority queue core.
// ----------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

  localparam int KEY_W        = 32;
  localparam int TAG_W        = 16;
  localparam int STATUS_W     = 2;
  localparam int OCC_W        = 8;
  localparam int DEF_CAPACITY = 255;

  // heap entry, key in the low bits
  typedef struct packed {
    logic [TAG_W-1:0]        tag;
    logic signed [KEY_W-1:0] key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // one result item, key in the low bits
  typedef struct packed {
    logic [OCC_W-1:0]        occupancy;
    logic [STATUS_W-1:0]     status;
    logic [TAG_W-1:0]        tag;
    logic signed [KEY_W-1:0] key;
  } res_t;

  localparam int RES_W      = $bits(res_t);
  localparam int S_TDATA_W  = ((ENTRY_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((RES_W + 7) / 8) * 8;

  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

@@ src/binary_heap_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_core
// Min/max binary heap of (key, tag) entries held in a dual-read memory.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   s_tdata = {tag, key}, s_tuser = kind
//  m_*       out  m_tvalid/m_tready   m_tdata = {occupancy, status, tag, key}
//  cfg_*     in   cfg_wen             cfg_wdata = max_order
//
//  One item at a time. Insert: the new entry rises one heap level per
//  read/compare pass until it stops or reaches the root, then is written
//  (into an empty heap it is written at once). Extract: the root is read
//  out and the last entry sinks one level per pass until it stops or
//  reaches a leaf. A refused item goes straight to the result. Each pass
//  is a read/compare loop round the store's registered read.
//  Reset (rst, synchronous) empties the heap and selects min order; memory
//  contents are not cleared, only slots up to the fill count are ever used.
//  A finished result sits in the output register; s_tready drops only while
//  an item is being worked, or when a new result finds the register still full.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_heap_priority_queue_core import bhpq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 cfg_wen,
  input  wire logic                 cfg_wdata,   // max_order
  // item in
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,     // [31:0] key, [47:32] tag
  input  wire logic                 s_tuser,     // kind
  // result out
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata      // [31:0] key, [47:32] tag,
                                                 // [49:48] status, [57:50] occupancy
);

  localparam int AW = $clog2(CAPACITY + 1);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  entry_t        rd_data_a;
  entry_t        rd_data_b;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  res_t          out_view;
  logic          out_refused;
  logic          out_blank;

  bhpq_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  bhpq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser),
    .in_entry  (entry_t'(s_tdata[ENTRY_W-1:0])),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: takes a result whenever empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
      m_tdata  <= M_TDATA_W'(res);
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign out_view    = res_t'(m_tdata[RES_W-1:0]);
  assign out_refused = m_tvalid &&
                       (out_view.status == ST_FULL || out_view.status == ST_EMPTY);
  assign out_blank   = (out_view.key == '0) && (out_view.tag == '0);

`include "binary_heap_priority_queue_core_assert.svh"

  `BHPQ_ASSERT_ALWAYS(a_rst_clears_out, rst |=> !m_tvalid, "result valid after reset")
  `BHPQ_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "item taken while busy")
  `BHPQ_ASSERT(a_occ_bound, m_tvalid |-> (out_view.occupancy <= CAPACITY), "occupancy over capacity")
  `BHPQ_ASSERT(a_refused_zero, out_refused |-> out_blank, "refused item carries data")

endmodule

`default_nettype wire

@@ src/bhpq_store.sv @@
// ----------------------------------------------------------------------------
// bhpq_store
// Heap entry memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_store import bhpq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int AW = $clog2(CAPACITY + 1)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic [AW-1:0] rd_addr_a,
  input  wire logic [AW-1:0] rd_addr_b,
  output entry_t             rd_data_a,
  output entry_t             rd_data_b
);

  // slot 0 unused, heap is one-based
  entry_t mem [CAPACITY + 1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

@@ src/bhpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bhpq_ctrl
// Sequencer for insert (sift up) and extract (sift down) over the store.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_ctrl import bhpq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int AW = $clog2(CAPACITY + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wen,
  input  wire logic          cfg_wdata,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_kind,
  input  wire entry_t        in_entry,
  output logic [AW-1:0]      rd_addr_a,
  output logic [AW-1:0]      rd_addr_b,
  input  wire entry_t        rd_data_a,
  input  wire entry_t        rd_data_b,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output entry_t             wr_data,
  output logic               res_valid,
  input  wire logic          res_ready,
  output res_t               res
);

  typedef enum logic [3:0] {
    IDLE, UP_RD, UP_CMP, EX_RD, EX_LOAD, DN_RD, DN_CMP, PUT, FINISH
  } state_t;

  state_t                  state;
  logic                    max_order;
  logic [AW-1:0]           count;
  logic [AW-1:0]           pos;
  logic [AW:0]             child;
  entry_t                  moving;
  logic signed [KEY_W-1:0] res_key;
  logic [TAG_W-1:0]        res_tag;
  logic [STATUS_W-1:0]     res_status;

  logic          up_move;
  logic          use_right;
  logic          dn_stop;
  entry_t        best;
  logic [AW:0]   child_inc;
  logic [AW:0]   best_idx;
  logic [AW:0]   best_child;
  logic [AW-1:0] parent_pos;

  function automatic logic ranks_before(input logic ord, input logic signed [KEY_W-1:0] a,
                                        input logic signed [KEY_W-1:0] b);
    return ord ? (a > b) : (a < b);
  endfunction

  assign child_inc  = child + (AW + 1)'(1);
  assign parent_pos = pos >> 1;
  assign up_move    = ranks_before(max_order, moving.key, rd_data_a.key);
  assign use_right  = ({1'b0, count} > child) &&
                      ranks_before(max_order, rd_data_b.key, rd_data_a.key);
  assign best       = use_right ? rd_data_b : rd_data_a;
  assign best_idx   = use_right ? child_inc : child;
  assign best_child = {best_idx[AW-1:0], 1'b0};
  // min order keeps moving on an equal key, max order stops on it
  assign dn_stop    = max_order ? (moving.key >= best.key) : (moving.key < best.key);

  // memory port drive
  always_comb begin
    rd_addr_a = '0;
    rd_addr_b = '0;
    wr_en     = 1'b0;
    wr_addr   = pos;
    wr_data   = moving;
    case (state)
      UP_RD: begin
        rd_addr_a = parent_pos;
      end
      UP_CMP: begin
        wr_en = 1'b1;
        if (up_move) begin
          wr_data = rd_data_a;
        end
      end
      EX_RD: begin
        rd_addr_a = AW'(1);
        rd_addr_b = count;
      end
      DN_RD: begin
        rd_addr_a = child[AW-1:0];
        rd_addr_b = child_inc[AW-1:0];
      end
      DN_CMP: begin
        wr_en = 1'b1;
        if (!dn_stop) begin
          wr_data = best;
        end
      end
      PUT: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign in_ready      = (state == IDLE);
  assign res_valid     = (state == FINISH);
  assign res.key       = res_key;
  assign res.tag       = res_tag;
  assign res.status    = res_status;
  assign res.occupancy = OCC_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      max_order  <= 1'b0;
      count      <= '0;
      pos        <= '0;
      child      <= '0;
      res_key    <= '0;
      res_tag    <= '0;
      res_status <= ST_DONE;
    end else begin
      case (state)
        IDLE: begin
          if (cfg_wen) begin
            max_order <= cfg_wdata;
          end
          if (in_valid) begin
            res_key    <= '0;
            res_tag    <= '0;
            res_status <= ST_DONE;
            if (in_kind == KIND_INSERT) begin
              if (count == AW'(CAPACITY)) begin
                res_status <= ST_FULL;
                state      <= FINISH;
              end else begin
                count  <= count + AW'(1);
                pos    <= count + AW'(1);
                moving <= in_entry;
                state  <= (count == '0) ? PUT : UP_RD;
              end
            end else begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= FINISH;
              end else begin
                state <= EX_RD;
              end
            end
          end
        end
        UP_RD: begin
          state <= UP_CMP;
        end
        UP_CMP: begin
          if (up_move) begin
            pos   <= parent_pos;
            state <= (parent_pos == AW'(1)) ? PUT : UP_RD;
          end else begin
            state <= FINISH;
          end
        end
        EX_RD: begin
          state <= EX_LOAD;
        end
        EX_LOAD: begin
          res_key <= rd_data_a.key;
          res_tag <= rd_data_a.tag;
          moving  <= rd_data_b;
          count   <= count - AW'(1);
          pos     <= AW'(1);
          child   <= (AW + 1)'(2);
          // fewer than two entries left: no child to compare
          state   <= (count < AW'(3)) ? PUT : DN_RD;
        end
        DN_RD: begin
          state <= DN_CMP;
        end
        DN_CMP: begin
          if (dn_stop) begin
            state <= FINISH;
          end else begin
            pos   <= best_idx[AW-1:0];
            child <= best_child;
            state <= (best_child > {1'b0, count}) ? PUT : DN_RD;
          end
        end
        PUT: begin
          state <= FINISH;
        end
        FINISH: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
